// ----- src/gar_pkg.sv -----
// Shared types, constants and the national swap tables of the glyph renderer.
`timescale 1ns / 1ps

package gar_pkg;

    localparam int GLYPH_COUNT   = 256;
    localparam int CODE_W        = 8;
    localparam int LOAD_ROW_W    = 4;
    localparam int BITS_W        = 8;
    localparam int HEIGHT_W      = 5;
    localparam int ROWNUM_W      = 4;
    localparam int LANG_W        = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 16;
    localparam int SWAP_MAX_PAIRS = 9;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    localparam logic [BITS_W-1:0] GREY_EVEN = 8'hAA;
    localparam logic [BITS_W-1:0] GREY_ODD  = 8'h55;

    // h/5 and rem/3 by reciprocal, exact for values below 32
    localparam int DIV5_MUL   = 13;
    localparam int DIV5_SHIFT = 6;
    localparam int DIV3_MUL   = 11;
    localparam int DIV3_SHIFT = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEIGHT  = 3'd0,
        CFG_BOLD    = 3'd1,
        CFG_GREY    = 3'd2,
        CFG_ITALIC  = 3'd3,
        CFG_REVERSE = 3'd4,
        CFG_ULINE   = 3'd5,
        CFG_LANG    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                bold;
        logic                grey;
        logic                italic;
        logic                reverse;
        logic [BITS_W-1:0]   underline;
        logic [LANG_W-1:0]   lang;
    } cfg_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic                  req;
        logic [CODE_W-1:0]     code;      // swapped for renders
        logic [LOAD_ROW_W-1:0] load_row;
        logic [BITS_W-1:0]     font_bits;
        logic                  load_ok;   // row within effective height
        logic [HEIGHT_W-1:0]   height;    // effective height
        logic [HEIGHT_W-1:0]   bnd1;      // italic band edges
        logic [HEIGHT_W-1:0]   bnd2;
        logic [HEIGHT_W-1:0]   bnd3;
        logic [HEIGHT_W-1:0]   bnd4;
        logic [HEIGHT_W-1:0]   bnd5;
    } cmd_t;

    localparam logic [3:0] SWAP_COUNT [0:7] = '{
        4'd0, 4'd8, 4'd8, 4'd1, 4'd6, 4'd9, 4'd7, 4'd5
    };

    localparam logic [7:0] SWAP_A [0:7][0:SWAP_MAX_PAIRS-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h00},
        '{8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h00},
        '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7C, 8'h7D, 8'h00, 8'h00, 8'h00},
        '{8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h7B, 8'h7C, 8'h7D, 8'h7E},
        '{8'h5B, 8'h5D, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h00, 8'h00},
        '{8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] SWAP_B [0:7][0:SWAP_MAX_PAIRS-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEA, 8'hA2, 8'hF5, 8'hA6, 8'hE1, 8'hEE, 8'hEB, 8'hB2, 8'h00},
        '{8'hA6, 8'hD0, 8'hD3, 8'hD4, 8'hF0, 8'hF3, 8'hF4, 8'hBA, 8'h00},
        '{8'hA3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hD6, 8'hD8, 8'hD7, 8'hF6, 8'hF8, 8'hF7, 8'h00, 8'h00, 8'h00},
        '{8'hC1, 8'hD0, 8'hD3, 8'hD7, 8'hD4, 8'hF0, 8'hF3, 8'hF7, 8'hF4},
        '{8'hA2, 8'hE1, 8'hEE, 8'hEA, 8'hED, 8'hEB, 8'hEC, 8'h00, 8'h00},
        '{8'hAF, 8'hD9, 8'hAE, 8'hB2, 8'hF9, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // first matching pair wins, either side of the pair
    function automatic logic [CODE_W-1:0] swap_code(input logic [CODE_W-1:0] code,
                                                   input logic [LANG_W-1:0] lang);
        logic [CODE_W-1:0] res;
        res = code;
        for (int i = SWAP_MAX_PAIRS - 1; i >= 0; i--) begin
            if (i < int'(SWAP_COUNT[lang])) begin
                if (code == SWAP_A[lang][i]) begin
                    res = SWAP_B[lang][i];
                end else if (code == SWAP_B[lang][i]) begin
                    res = SWAP_A[lang][i];
                end
            end
        end
        return res;
    endfunction

endpackage

// ----- src/gar_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module gar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/gar_fifo.sv -----
// Short command queue between front and back.
`timescale 1ns / 1ps

module gar_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- src/gar_front.sv -----
// Front end: accepts items, swaps codes, works out height and italic bands.
`timescale 1ns / 1ps

module gar_front #(
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gar_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  gar_pkg::cfg_t                cfg,
    input  logic                         q_full,
    output logic                         q_push,
    output gar_pkg::cmd_t                q_cmd
);

    import gar_pkg::*;

    logic [CODE_W-1:0]     in_code;
    logic [LOAD_ROW_W-1:0] in_row;
    logic [BITS_W-1:0]     in_bits;
    logic [HEIGHT_W-1:0]   h;
    logic [9:0]            p5;
    logic [8:0]            p3;
    logic [HEIGHT_W-1:0]   s1, s2, s3, rem, b2;

    assign in_code = s_tdata[7:0];
    assign in_row  = s_tdata[11:8];
    assign in_bits = s_tdata[19:12];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        if (cfg.height == '0) begin
            h = HEIGHT_W'(1);
        end else if (int'(cfg.height) > MAX_GLYPH_ROWS) begin
            h = HEIGHT_W'(MAX_GLYPH_ROWS);
        end else begin
            h = cfg.height;
        end
    end

    // band sizes: s1 = h/5, s2 = (h-2*s1)/3, s3 takes the rest of the middle
    always_comb begin
        p5  = 10'(h) * 10'(DIV5_MUL);
        s1  = HEIGHT_W'(p5 >> DIV5_SHIFT);
        rem = h - HEIGHT_W'({s1, 1'b0});
        p3  = 9'(rem) * 9'(DIV3_MUL);
        s2  = HEIGHT_W'(p3 >> DIV3_SHIFT);
        s3  = rem - HEIGHT_W'({s2, 1'b0});
        b2  = s1 + s2 + s3;
    end

    always_comb begin
        q_cmd.req       = s_tuser;
        q_cmd.code      = (s_tuser == REQ_RENDER) ? swap_code(in_code, cfg.lang) : in_code;
        q_cmd.load_row  = in_row;
        q_cmd.font_bits = in_bits;
        q_cmd.load_ok   = (HEIGHT_W'(in_row) < h);
        q_cmd.height    = h;
        q_cmd.bnd1      = s1;
        q_cmd.bnd2      = s1 + s2;
        q_cmd.bnd3      = b2;
        q_cmd.bnd4      = b2 + s2;
        q_cmd.bnd5      = b2 + s2 + s1;
    end

endmodule

// ----- src/gar_back.sv -----
// Back end: font memory port, row sequencer, styling and output register.
`timescale 1ns / 1ps

module gar_back #(
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gar_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  gar_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gar_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import gar_pkg::*;

    localparam int ROW_W  = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
    localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef enum logic [2:0] {
        SH_NONE = 3'd0,
        SH_R2   = 3'd1,
        SH_R1   = 3'd2,
        SH_L1   = 3'd3,
        SH_L2   = 3'd4
    } shift_t;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    cmd_t                cur_reg, cur_next;

    logic                pend_reg, pend_next;
    logic [ROW_W-1:0]    pend_row_reg;
    logic                pend_last_reg;
    shift_t              pend_shift_reg;

    logic                out_valid_reg, out_valid_next;
    logic [BITS_W-1:0]   out_bits_reg;
    logic [ROWNUM_W-1:0] out_row_reg;
    logic                out_last_reg;

    cmd_t                act;
    logic [ROW_W-1:0]    act_row;
    logic [HEIGHT_W-1:0] n;
    logic                running, head_load, head_render;
    logic                move, can_issue, issue, act_last, load_wr;
    shift_t              iss_shift;

    logic [ADDR_W-1:0]   ram_addr;
    logic [BITS_W-1:0]   ram_rdata;
    logic [BITS_W-1:0]   styled;

    assign running     = (state_reg == ST_RUN);
    assign head_load   = !running && q_valid && (q_cmd.req == REQ_LOAD);
    assign head_render = !running && q_valid && (q_cmd.req == REQ_RENDER);

    assign act     = running ? cur_reg : q_cmd;
    assign act_row = running ? row_reg : '0;
    assign n       = HEIGHT_W'(act_row);

    assign move      = pend_reg && (!out_valid_reg || m_tready);
    assign can_issue = !pend_reg || move;
    assign issue     = (running || head_render) && can_issue;
    assign act_last  = (n == act.height - 1'b1);
    assign load_wr   = head_load && q_cmd.load_ok;
    assign q_pop     = head_load || (head_render && issue);

    always_comb begin
        if (n < act.bnd1) begin
            iss_shift = SH_R2;
        end else if (n < act.bnd2) begin
            iss_shift = SH_R1;
        end else if (n >= act.bnd3 && n < act.bnd4) begin
            iss_shift = SH_L1;
        end else if (n >= act.bnd4 && n < act.bnd5) begin
            iss_shift = SH_L2;
        end else begin
            iss_shift = SH_NONE;
        end
    end

    always_comb begin
        if (head_load) begin
            ram_addr = ADDR_W'(q_cmd.code) * ADDR_W'(MAX_GLYPH_ROWS)
                     + ADDR_W'(q_cmd.load_row);
        end else begin
            ram_addr = ADDR_W'(act.code) * ADDR_W'(MAX_GLYPH_ROWS) + ADDR_W'(act_row);
        end
    end

    gar_ram #(
        .WIDTH (BITS_W),
        .DEPTH (DEPTH)
    ) u_font (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (load_wr),
        .wdata (q_cmd.font_bits),
        .re    (issue),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        if (issue) begin
            if (head_render) begin
                cur_next = q_cmd;
            end
            if (act_last) begin
                state_next = ST_IDLE;
                row_next   = '0;
            end else begin
                state_next = ST_RUN;
                row_next   = act_row + 1'b1;
            end
        end
    end

    // styling order: bold, grey, italic, underline, reverse
    always_comb begin
        styled = ram_rdata;
        if (cfg.bold) begin
            styled = styled | (styled >> 1);
        end
        if (cfg.grey) begin
            styled = styled & (pend_row_reg[0] ? GREY_ODD : GREY_EVEN);
        end
        if (cfg.italic) begin
            case (pend_shift_reg)
                SH_R2:   styled = styled >> 2;
                SH_R1:   styled = styled >> 1;
                SH_L1:   styled = styled << 1;
                SH_L2:   styled = styled << 2;
                default: styled = styled;
            endcase
        end
        if (pend_last_reg) begin
            styled = styled | cfg.underline;
        end
        if (cfg.reverse) begin
            styled = ~styled;
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (issue) begin
            pend_next = 1'b1;
        end else if (move) begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (issue) begin
            pend_row_reg   <= act_row;
            pend_last_reg  <= act_last;
            pend_shift_reg <= iss_shift;
        end
        if (move) begin
            out_bits_reg <= styled;
            out_row_reg  <= ROWNUM_W'(pend_row_reg);
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BITS_W - ROWNUM_W){1'b0}}, out_row_reg, out_bits_reg};
    assign m_tlast  = out_last_reg;

    a_run_is_render: assert property (@(posedge aclk) disable iff (!aresetn)
        running |-> cur_reg.req == REQ_RENDER)
        else $error("row sequencer running on a load command");

    a_row_in_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        running |-> HEIGHT_W'(row_reg) < cur_reg.height)
        else $error("row counter beyond glyph height");

    a_pend_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_reg) |-> $past(issue))
        else $error("read data marked pending without a read");

    a_more_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && !act_last |=> running)
        else $error("sequencer stopped before the last row");

    a_no_load_while_run: assert property (@(posedge aclk) disable iff (!aresetn)
        running |-> !load_wr && !q_pop)
        else $error("queue popped during a render");

endmodule

// ----- src/glyph_attribute_renderer.sv -----
// Top level of the text-mode glyph renderer: ports, configuration registers, wiring.
`timescale 1ns / 1ps

// Text-mode character generator. A load item (tuser = 0) writes one font row of
// one glyph; a render item (tuser = 1) emits every row of its glyph, one output
// item per row, tlast on the final row, styled by the configuration registers
// (bold, grey checker, italic bands, underline, reverse). Items are classified
// by a front end and queued (FIFO_DEPTH commands) for the back end, which owns
// the single font memory port. A render of an h-row glyph holds that port for
// its h row reads, one row read per cycle while the output is not stalled, and
// no later item reaches the port until its last row is read. The first row
// passes through the queue, the font read and the output register on its way
// out. A load takes the port once and produces nothing. Rows leave
// through a read stage and an output register, so when the receiver stalls the
// front keeps taking items only until the queue fills.
// Font rows are undefined until loaded: there is no clearing pass after reset.
// Configuration writes are accepted at any time (cfg_ready is always high) but
// must only be issued while the block is idle.
module glyph_attribute_renderer #(
    parameter int MAX_GLYPH_ROWS = 16,
    parameter int FIFO_DEPTH     = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] char_code, [11:8] load_row, [19:12] font_row_bits, [23:20] zero
    input  logic [gar_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  logic                            s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] row_bits, [11:8] row_number, [15:12] zero
    output logic [gar_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_row
    output logic                            m_tlast,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gar_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import gar_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_wcmd, q_rcmd;
    logic [$bits(cmd_t)-1:0] q_rdata;

    assign cfg_ready = 1'b1;

    // register writes; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HEIGHT:  cfg_next.height    = cfg_data[HEIGHT_W-1:0];
                CFG_BOLD:    cfg_next.bold      = cfg_data[0];
                CFG_GREY:    cfg_next.grey      = cfg_data[0];
                CFG_ITALIC:  cfg_next.italic    = cfg_data[0];
                CFG_REVERSE: cfg_next.reverse   = cfg_data[0];
                CFG_ULINE:   cfg_next.underline = cfg_data[BITS_W-1:0];
                CFG_LANG:    cfg_next.lang      = cfg_data[LANG_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height    <= HEIGHT_W'(16);
            cfg_reg.bold      <= 1'b0;
            cfg_reg.grey      <= 1'b0;
            cfg_reg.italic    <= 1'b0;
            cfg_reg.reverse   <= 1'b0;
            cfg_reg.underline <= '0;
            cfg_reg.lang      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify and decode each item
    gar_front #(
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_wcmd)
    );

    // queue decouples the input side from the font port
    gar_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wcmd),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .valid   (q_valid)
    );

    assign q_rcmd = cmd_t'(q_rdata);

    // back: font memory, row sequencing, styling
    gar_back #(
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_rcmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- verif/glyph_attribute_renderer_tb.sv -----
// Self-checking testbench for the text-mode glyph renderer: directed and random traffic.
`timescale 1ns / 1ps

// The bench keeps its own copy of the font store and of the style settings.
// Every accepted item goes through the same steps as the block:
//   load   -> store the row, unless the row is at or beyond the height
//   render -> national swap, then bold, grey, italic, underline, reverse,
//             with one expected row queued per glyph row
// A monitor pops one expected row for each row that leaves the block.
// Renders only touch font rows the bench has loaded, because unloaded rows
// hold no defined value.
module glyph_attribute_renderer_tb;
    import gar_pkg::*;

    localparam int  TIMEOUT_NS    = 2_000_000;
    localparam int  RANDOM_ITEMS  = 500;
    localparam int  SETTLE_CYCLES = 32;    // front end plus command FIFO, generous
    localparam int  CHUNK_ITEMS   = 12;    // random items between setting changes
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    // national swap pairs {code_a, code_b}, first matching pair wins
    localparam int NAT_COUNT [0:7] = '{0, 8, 8, 1, 6, 9, 7, 5};
    localparam logic [15:0] NAT_PAIRS [0:7][0:8] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h40EA, 16'h5BA2, 16'h5CF5, 16'h5DA6, 16'h7BE1,
          16'h7CEE, 16'h7DEB, 16'h7EB2, 16'h0000},
        '{16'h40A6, 16'h5BD0, 16'h5CD3, 16'h5DD4, 16'h7BF0,
          16'h7CF3, 16'h7DF4, 16'h7EBA, 16'h0000},
        '{16'h23A3, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h5BD6, 16'h5CD8, 16'h5DD7, 16'h7BF6, 16'h7CF8,
          16'h7DF7, 16'h0000, 16'h0000, 16'h0000},
        '{16'h40C1, 16'h5BD0, 16'h5CD3, 16'h5DD7, 16'h5ED4,
          16'h7BF0, 16'h7CF3, 16'h7DF7, 16'h7EF4},
        '{16'h5BA2, 16'h5DE1, 16'h60EE, 16'h7BEA, 16'h7CED,
          16'h7DEB, 16'h7EEC, 16'h0000, 16'h0000},
        '{16'h5BAF, 16'h5CD9, 16'h5DAE, 16'h7BB2, 16'h7CF9,
          16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };

    typedef struct packed {
        logic [BITS_W-1:0]   bits;
        logic [ROWNUM_W-1:0] num;
        logic                last;
    } glyph_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // bench copy of the block state
    logic [BITS_W-1:0]   font_q    [0:4095];
    bit                  font_seen [0:4095];
    logic [HEIGHT_W-1:0] height_q  = 5'd16;
    logic                bold_q    = 1'b0;
    logic                grey_q    = 1'b0;
    logic                italic_q  = 1'b0;
    logic                reverse_q = 1'b0;
    logic [BITS_W-1:0]   uline_q   = '0;
    logic [LANG_W-1:0]   lang_q    = '0;

    glyph_row_t rows_due [$];
    int         mismatches     = 0;
    int         items_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    glyph_attribute_renderer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    // height 0 behaves as 1, anything above 16 as 16
    function automatic int eff_height();
        if (height_q == 0) return 1;
        if (height_q > 16) return 16;
        return int'(height_q);
    endfunction

    function automatic logic [CODE_W-1:0] national_code(input logic [CODE_W-1:0] code,
                                                        input logic [LANG_W-1:0] lang);
        for (int i = 0; i < NAT_COUNT[lang]; i++) begin
            if (code == NAT_PAIRS[lang][i][15:8]) return NAT_PAIRS[lang][i][7:0];
            if (code == NAT_PAIRS[lang][i][7:0])  return NAT_PAIRS[lang][i][15:8];
        end
        return code;
    endfunction

    // five bands: two shifted right at the top, two shifted left at the foot,
    // anything shifted out of the byte is lost
    function automatic logic [BITS_W-1:0] slant_row(input logic [BITS_W-1:0] v,
                                                    input int n, input int h);
        int s1, rem, s2, s3, b2;
        s1  = h / 5;
        rem = h - 2 * s1;
        s2  = rem / 3;
        s3  = rem - 2 * s2;
        b2  = s1 + s2 + s3;
        if (n < s1) return v >> 2;
        if (n < s1 + s2) return v >> 1;
        if (n >= b2 && n < b2 + s2) return v << 1;
        if (n >= b2 + s2 && n < b2 + s2 + s1) return v << 2;
        return v;
    endfunction

    function automatic logic [BITS_W-1:0] style_row(input logic [BITS_W-1:0] raw,
                                                    input int n, input int h);
        logic [BITS_W-1:0] v;
        v = raw;
        if (bold_q) v = v | (v >> 1);
        if (grey_q) v = v & ((n % 2) ? GREY_ODD : GREY_EVEN);
        if (italic_q) v = slant_row(v, n, h);
        if (n == h - 1) v = v | uline_q;
        if (reverse_q) v = ~v;
        return v;
    endfunction

    task automatic apply_item(input logic req, input logic [CODE_W-1:0] code,
                              input logic [LOAD_ROW_W-1:0] lrow,
                              input logic [BITS_W-1:0] bits);
        int h;
        logic [CODE_W-1:0] glyph;
        glyph_row_t row;
        h = eff_height();
        if (req == REQ_LOAD) begin
            // loads use the code as given; rows past the height are dropped
            if (int'(lrow) < h) begin
                font_q[{code, lrow}]    = bits;
                font_seen[{code, lrow}] = 1'b1;
            end
        end else begin
            glyph = national_code(code, lang_q);
            for (int n = 0; n < h; n++) begin
                row.bits = style_row(font_q[{glyph, 4'(n)}], n, h);
                row.num  = 4'(n);
                row.last = (n == h - 1);
                rows_due.push_back(row);
            end
        end
    endtask

    task automatic note_setting(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HEIGHT:  height_q  = data[HEIGHT_W-1:0];
            CFG_BOLD:    bold_q    = data[0];
            CFG_GREY:    grey_q    = data[0];
            CFG_ITALIC:  italic_q  = data[0];
            CFG_REVERSE: reverse_q = data[0];
            CFG_ULINE:   uline_q   = data;
            CFG_LANG:    lang_q    = data[LANG_W-1:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    // Entered and left at a falling edge. tvalid stays high on return so that
    // back-to-back items need no gap; drain() lowers it.
    task automatic send_item(input logic req, input logic [CODE_W-1:0] code,
                             input logic [LOAD_ROW_W-1:0] lrow,
                             input logic [BITS_W-1:0] bits);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0000, bits, lrow, code};
        do @(posedge aclk); while (!s_tready);
        apply_item(req, code, lrow, bits);
        items_sent++;
        @(negedge aclk);
    endtask

    // sender holds off until every expected row is out and the pipe has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // settings only change with the block idle
    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        note_setting(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // load whatever rows of the (swapped) glyph are still unknown, then render
    task automatic render_char(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] glyph;
        int h;
        h     = eff_height();
        glyph = national_code(code, lang_q);
        for (int r = 0; r < h; r++) begin
            if (!font_seen[{glyph, 4'(r)}])
                send_item(REQ_LOAD, glyph, 4'(r), 8'($urandom_range(0, 255)));
        end
        send_item(REQ_RENDER, code, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [CODE_W-1:0] national_pick();
        int l, i;
        l = $urandom_range(1, 7);
        i = $urandom_range(0, NAT_COUNT[l] - 1);
        return $urandom_range(0, 1) ? NAT_PAIRS[l][i][15:8] : NAT_PAIRS[l][i][7:0];
    endfunction

    // ---------------------------------------------------------------- tests

    // all-clear and all-set rows on the lowest code, two mixed rows on the highest
    task automatic test_plain_glyphs();
        write_setting(CFG_HEIGHT, 8'd2);
        send_item(REQ_LOAD, 8'h00, 4'd0, 8'h00);
        send_item(REQ_LOAD, 8'h00, 4'd1, 8'hFF);
        send_item(REQ_LOAD, 8'hFF, 4'd0, 8'h81);
        send_item(REQ_LOAD, 8'hFF, 4'd1, 8'h7E);
        send_item(REQ_RENDER, 8'h00, 4'd15, 8'hFF);
        send_item(REQ_RENDER, 8'hFF, 4'd0, 8'h00);
    endtask

    // loads at or beyond the height must leave the store alone
    task automatic test_ignored_loads();
        write_setting(CFG_HEIGHT, 8'd1);
        send_item(REQ_LOAD, 8'hFF, 4'd1, 8'h00);
        send_item(REQ_LOAD, 8'h00, 4'd15, 8'hFF);
        send_item(REQ_RENDER, 8'h00, 4'd0, 8'h00);
        write_setting(CFG_HEIGHT, 8'd2);
        send_item(REQ_RENDER, 8'hFF, 4'd0, 8'h00);
    endtask

    // each style alone, then reverse with underline, on a five-row glyph, where every italic band is one row
    task automatic test_styles();
        write_setting(CFG_HEIGHT, 8'd5);
        render_char(8'h41);
        write_setting(CFG_BOLD, 8'd1);
        render_char(8'h41);
        write_setting(CFG_BOLD, 8'd0);
        write_setting(CFG_GREY, 8'd1);
        render_char(8'h41);
        write_setting(CFG_GREY, 8'd0);
        write_setting(CFG_ITALIC, 8'd1);
        render_char(8'h41);
        write_setting(CFG_ITALIC, 8'd0);
        write_setting(CFG_REVERSE, 8'd1);
        write_setting(CFG_ULINE, 8'hFF);
        render_char(8'h41);
        write_setting(CFG_REVERSE, 8'hFE);     // only bit 0 counts
        write_setting(CFG_ULINE, 8'h00);
    endtask

    // height 0 acts as one row, heights above the glyph size as the full glyph
    task automatic test_height_clamp();
        write_setting(CFG_HEIGHT, 8'd0);
        render_char(8'h00);
        write_setting(CFG_HEIGHT, 8'd31);
        write_setting(CFG_ULINE, 8'h81);
        render_char(8'h41);
        write_setting(CFG_ULINE, 8'h00);
    endtask

    // swapped renders read the partner glyph, loads land on the code given
    task automatic test_national_tables();
        write_setting(CFG_HEIGHT, 8'd1);
        send_item(REQ_LOAD, 8'h23, 4'd0, 8'h3C);
        send_item(REQ_LOAD, 8'hA3, 4'd0, 8'hC3);
        write_setting(CFG_LANG, 8'd3);
        send_item(REQ_RENDER, 8'h23, 4'd0, 8'h00);
        send_item(REQ_RENDER, 8'hA3, 4'd0, 8'h00);
        write_setting(CFG_LANG, 8'd5);
        render_char(8'hF4);
        write_setting(CFG_LANG, 8'hF8);        // upper bits dropped, table 0
        render_char(8'h23);
    endtask

    task automatic random_settings();
        write_setting(CFG_HEIGHT,  8'($urandom_range(0, 255)));
        write_setting(CFG_BOLD,    8'($urandom_range(0, 255)));
        write_setting(CFG_GREY,    8'($urandom_range(0, 255)));
        write_setting(CFG_ITALIC,  8'($urandom_range(0, 255)));
        write_setting(CFG_REVERSE, 8'($urandom_range(0, 255)));
        write_setting(CFG_ULINE,   8'($urandom_range(0, 255)));
        write_setting(CFG_LANG,    8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            write_setting(CFG_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    // mostly complete glyph sequences, some stray loads (possibly out of height)
    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            send_item(REQ_LOAD, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
        else if (sel < 65)
            render_char(national_pick());
        else
            render_char(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int first;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 32; recv_stall_pct = 51; end
                1: begin send_idle_pct = 51; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            first = items_sent;
            while (items_sent - first < RANDOM_ITEMS / 3) begin
                random_settings();
                repeat (CHUNK_ITEMS)
                    if (items_sent - first < RANDOM_ITEMS / 3) random_item();
            end
        end
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin : row_check
        glyph_row_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                $display("%0t: row with none expected, expected nothing, actual %02h/%0d/%0b",
                         $time, m_tdata[7:0], m_tdata[11:8], m_tlast);
                mismatches++;
            end else begin
                due = rows_due.pop_front();
                if (m_tdata[7:0] !== due.bits) begin
                    $display("%0t: row_bits mismatch, expected %02h, actual %02h",
                             $time, due.bits, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[11:8] !== due.num) begin
                    $display("%0t: row_number mismatch, expected %0d, actual %0d",
                             $time, due.num, m_tdata[11:8]);
                    mismatches++;
                end
                if (m_tlast !== due.last) begin
                    $display("%0t: last_row mismatch, expected %0b, actual %0b",
                             $time, due.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 32;
        recv_stall_pct = 51;
        test_plain_glyphs();
        test_ignored_loads();
        test_styles();
        test_height_clamp();
        test_national_tables();
        test_random_traffic();

        drain();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
